### design/kmst_pkg.sv
// Shared types and constants for the union-find spanning tree accumulator.
package kmst_pkg;

  localparam int NODES_DEF = 1024;
  localparam int VERTEX_W  = 10;
  localparam int WEIGHT_W  = 32;
  localparam int TOTAL_W   = 48;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic                new_graph;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
  } kmst_in_t;

  typedef struct packed {
    logic               edge_joined;
    logic [TOTAL_W-1:0] total_cost;
  } kmst_out_t;

  // Source of the single parent table write port.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_COMPRESS,
    WR_LINK
  } kmst_wr_t;

  typedef struct packed {
    logic     capture;
    logic     clr_start;
    kmst_wr_t wr;
    logic     rd;
    logic     side;
    logic     load_a;
    logic     load_b;
    logic     adv_cur;
    logic     set_root;
    logic     load_out;
  } kmst_cmd_t;

  typedef struct packed {
    logic new_graph;
    logic in_range;
    logic clr_last;
    logic rdata_is_cur;
    logic cur_is_root;
    logic out_free;
  } kmst_status_t;

endpackage

### design/kmst_ram.sv
// Generic single write port RAM with a registered read port.
module kmst_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/kmst_dpath.sv
// Datapath: parent table, walk pointer, roots, running total and output word.
module kmst_dpath import kmst_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  kmst_in_t     in_data,
  input  kmst_cmd_t    cmd,
  output kmst_status_t status,
  output logic         out_valid,
  input  logic         out_stall,
  output kmst_out_t    out_data
);

  // Vertex numbers cannot exceed the field width, so the table never needs more.
  localparam int MEM_DEPTH = (NODES > (2 ** VERTEX_W)) ? (2 ** VERTEX_W) : NODES;
  localparam int AW        = $clog2(MEM_DEPTH);

  kmst_in_t           item_r;
  logic [AW-1:0]      clr_idx_r;
  logic [AW-1:0]      cur_r;
  logic [AW-1:0]      root_a_r;
  logic [AW-1:0]      root_b_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic               joined_r;
  logic               out_valid_r;
  kmst_out_t          out_data_r;

  logic [AW-1:0]      vert_a;
  logic [AW-1:0]      vert_b;
  logic [AW-1:0]      side_vertex;
  logic [AW-1:0]      side_root;
  logic [AW-1:0]      rd_data;
  logic               roots_differ;
  logic [TOTAL_W:0]   sum;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      wr_data;

  assign vert_a       = item_r.vertex_a[AW-1:0];
  assign vert_b       = item_r.vertex_b[AW-1:0];
  assign side_vertex  = cmd.side ? vert_b : vert_a;
  assign side_root    = cmd.side ? root_b_r : root_a_r;
  assign roots_differ = (root_a_r != root_b_r);

  assign sum       = {1'b0, total_r} + (TOTAL_W + 1)'(item_r.edge_weight);
  assign total_nxt = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_data = side_root;
    case (cmd.wr)
      WR_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        wr_data = clr_idx_r;
      end
      WR_COMPRESS: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = side_root;
      end
      WR_LINK: begin
        // The larger root goes under the smaller one.
        wr_en   = roots_differ;
        wr_addr = (root_a_r < root_b_r) ? root_b_r : root_a_r;
        wr_data = (root_a_r < root_b_r) ? root_a_r : root_b_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  kmst_ram #(
    .WIDTH (AW),
    .DEPTH (MEM_DEPTH)
  ) u_parent (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (cur_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      total_r     <= '0;
      joined_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        clr_idx_r <= '0;
        total_r   <= '0;
      end else if (cmd.wr == WR_CLEAR) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end else if (cmd.wr == WR_LINK && roots_differ) begin
        total_r <= total_nxt;
      end
      if (cmd.capture) begin
        joined_r <= 1'b0;
      end else if (cmd.wr == WR_LINK && roots_differ) begin
        joined_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.load_a) begin
      cur_r <= vert_a;
    end else if (cmd.load_b) begin
      cur_r <= vert_b;
    end else if (cmd.set_root) begin
      cur_r <= side_vertex;
    end else if (cmd.adv_cur || cmd.wr == WR_COMPRESS) begin
      cur_r <= rd_data;
    end
    if (cmd.set_root && !cmd.side) begin
      root_a_r <= cur_r;
    end
    if (cmd.set_root && cmd.side) begin
      root_b_r <= cur_r;
    end
    if (cmd.load_out) begin
      out_data_r.edge_joined <= joined_r;
      out_data_r.total_cost  <= total_r;
    end
  end

  assign status.new_graph    = item_r.new_graph;
  assign status.in_range     = (32'(item_r.vertex_a) < 32'(NODES)) &&
                               (32'(item_r.vertex_b) < 32'(NODES));
  assign status.clr_last     = (clr_idx_r == AW'(MEM_DEPTH - 1));
  assign status.rdata_is_cur = (rd_data == cur_r);
  assign status.cur_is_root  = (cur_r == side_root);
  assign status.out_free     = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clr_start |=> total_r >= $past(total_r))
    else $error("running total fell without a clear");

  a_compress_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr == WR_COMPRESS |-> cur_r != side_root)
    else $error("compression write aimed at the root itself");

  a_load_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid && out_data.total_cost == $past(total_r))
    else $error("loaded result word not presented");
`endif

endmodule

### design/kmst_ctrl.sv
// Controller: sequences clearing, the two root walks, compression and linking.
module kmst_ctrl import kmst_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  kmst_status_t status,
  output kmst_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_BOOT,
    S_BOOT_CLR,
    S_IDLE,
    S_CHECK,
    S_CLEAR,
    S_START,
    S_RD,
    S_CHK,
    S_CMP_TEST,
    S_CMP_RD,
    S_CMP_WR,
    S_LINK,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   side_r;
  logic   side_nxt;

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    cmd       = '0;
    cmd.wr    = WR_NONE;
    cmd.side  = side_r;
    case (state_r)
      S_BOOT: begin
        cmd.clr_start = 1'b1;
        state_nxt     = S_BOOT_CLR;
      end
      S_BOOT_CLR: begin
        cmd.wr = WR_CLEAR;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.new_graph) begin
          cmd.clr_start = 1'b1;
          state_nxt     = S_CLEAR;
        end else begin
          state_nxt = S_START;
        end
      end
      S_CLEAR: begin
        cmd.wr = WR_CLEAR;
        if (status.clr_last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (status.in_range) begin
          cmd.load_a = 1'b1;
          side_nxt   = 1'b0;
          state_nxt  = S_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (status.rdata_is_cur) begin
          cmd.set_root = 1'b1;
          state_nxt    = S_CMP_TEST;
        end else begin
          cmd.adv_cur = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_CMP_TEST: begin
        if (!status.cur_is_root) begin
          state_nxt = S_CMP_RD;
        end else if (!side_r) begin
          cmd.load_b = 1'b1;
          side_nxt   = 1'b1;
          state_nxt  = S_RD;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_CMP_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP_WR;
      end
      S_CMP_WR: begin
        cmd.wr    = WR_COMPRESS;
        state_nxt = S_CMP_TEST;
      end
      S_LINK: begin
        cmd.wr    = WR_LINK;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_BOOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("controller took a second word while busy");
`endif

endmodule

### design/kruskal_union_find_mst.sv
// Top level of the union-find spanning tree accumulator.
//
//   Channel  Direction  Handshake           Word
//   in_      input      in_valid/in_stall   kmst_in_t  (new_graph, weight, two vertices)
//   out_     output     out_valid/out_stall kmst_out_t (joined flag, 48-bit total)
//
// An accepted edge passes S_CHECK and S_START and, with both endpoints in
// range, walks from each to its root with an S_RD read and an S_CHK test per
// parent hop; each compression write passes S_CMP_TEST, S_CMP_RD and S_CMP_WR.
// S_LINK then links differing roots and S_FIN loads the result word; only then
// is the next word taken. A word with new_graph set first sweeps the whole
// parent table, one entry per cycle, min(NODES, 1024) entries. After reset the
// same sweep runs once, with in_stall high, before the first word is taken. A
// stalled result sits in the output register while the controller returns to
// idle; the next edge waits only for that register to free before it ends.
module kruskal_union_find_mst import kmst_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  kmst_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output kmst_out_t out_data
);

  kmst_cmd_t    cmd;
  kmst_status_t status;

  // The controller decides the order of table reads and writes; the datapath
  // owns every register that carries edge data.
  kmst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  kmst_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sim/kruskal_union_find_mst_tb.sv
// Self-checking testbench for the union-find spanning tree accumulator.
module kruskal_union_find_mst_tb;
  import kmst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES       = NODES_DEF;
  localparam int EDGE_TARGET = 1750;
  // A typical run is long: it holds about a hundred table sweeps, edges whose
  // root walks cross a few dozen nodes, and random stalls on both sides.
  // CYCLE_LIMIT caps even the slowest run.
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int SETTLE      = 64;
  localparam int SHOWN_MAX   = 10;

  // Shadow union-find forest. It predicts the word that each accepted edge
  // must produce and compares the block's words against it in order.
  class mst_scoreboard;
    logic [VERTEX_W-1:0] parent [NODES];
    logic [TOTAL_W-1:0]  total;
    kmst_out_t           expected_q[$];
    int                  mismatches;
    int                  checked;
    int                  joins;

    function new();
      clear_forest();
      mismatches = 0;
      checked    = 0;
      joins      = 0;
    endfunction

    function void clear_forest();
      for (int i = 0; i < NODES; i++) parent[i] = VERTEX_W'(i);
      total = '0;
    endfunction

    // Walks to the root, then points every node on the path straight at it.
    function int find_root(int v);
      int r;
      int nxt;
      r = v;
      while (int'(parent[r]) != r) r = int'(parent[r]);
      while (v != r) begin
        nxt       = int'(parent[v]);
        parent[v] = VERTEX_W'(r);
        v         = nxt;
      end
      return r;
    endfunction

    function void note_edge(kmst_in_t w);
      kmst_out_t want;
      int        ra;
      int        rb;
      want = '0;
      if (w.new_graph) clear_forest();
      // An endpoint beyond the table leaves everything untouched.
      if (int'(w.vertex_a) < NODES && int'(w.vertex_b) < NODES) begin
        ra = find_root(int'(w.vertex_a));
        rb = find_root(int'(w.vertex_b));
        if (ra != rb) begin
          if (ra < rb) parent[rb] = VERTEX_W'(ra);
          else parent[ra] = VERTEX_W'(rb);
          if ({16'd0, w.edge_weight} > TOTAL_MAX - total) total = TOTAL_MAX;
          else total = total + {16'd0, w.edge_weight};
          want.edge_joined = 1'b1;
          joins++;
        end
      end
      want.total_cost = total;
      expected_q.insert(expected_q.size(), want);
    endfunction

    function void check_result(kmst_out_t got);
      kmst_out_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("%t: result word with nothing expected: joined=%0b total=%0d",
                   $realtime, got.edge_joined, got.total_cost);
        return;
      end
      want = expected_q.pop_front();
      if (got.edge_joined !== want.edge_joined || got.total_cost !== want.total_cost) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("%t: word %0d differs: joined exp %0b got %0b, total exp %0d got %0d",
                   $realtime, checked, want.edge_joined, got.edge_joined,
                   want.total_cost, got.total_cost);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  kmst_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  kmst_out_t out_data;

  mst_scoreboard sb = new();

  // While calm is set neither side idles, giving a long unbroken stretch.
  bit calm;
  int cycles = 0;
  int edges_sent;
  int graphs_started;

  kruskal_union_find_mst #(.NODES(NODES)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle count and the overall time limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Time limit of %0d cycles reached with %0d words outstanding",
               CYCLE_LIMIT, sb.pending());
      $display("kruskal_union_find_mst verification failed");
      $finish;
    end
  end

  // The receiver stalls on roughly one cycle in five, except in the calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 20);
  end

  // Every result word taken at a rising edge goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Presents one edge word from a falling edge and holds it until it is taken.
  // Random idle cycles go in front, so gaps fall on every phase of the block.
  task automatic send_edge(input kmst_in_t w);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_edge(w);
    edges_sent++;
    if (w.new_graph) graphs_started++;
    calm = (edges_sent >= 700 && edges_sent < 1000);
    @(negedge clk);
  endtask

  task automatic send_fields(input bit fresh, input logic [WEIGHT_W-1:0] wt,
                             input int a, input int b);
    kmst_in_t w;
    w.new_graph   = fresh;
    w.edge_weight = wt;
    w.vertex_a    = a[VERTEX_W-1:0];
    w.vertex_b    = b[VERTEX_W-1:0];
    send_edge(w);
  endtask

  // One well-formed graph: a small window of vertices somewhere in the table,
  // edges in ascending weight, with some noise edges and rare restarts mixed in.
  task automatic send_graph();
    int                  span;
    int                  base;
    int                  count;
    int                  step;
    logic [WEIGHT_W:0]   sum;
    logic [WEIGHT_W-1:0] wt;
    logic [63:0]         raw;
    kmst_in_t            w;
    span  = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(3, 24);
    base  = $urandom_range(NODES - span);
    count = $urandom_range(span / 2 + 1, span * 2);
    case ($urandom_range(3))
      0: begin
        wt   = '0;
        step = 3;
      end
      1: begin
        wt   = $urandom_range(1000);
        step = 200;
      end
      2: begin
        wt   = $urandom();
        step = 1 << 20;
      end
      default: begin
        wt   = 32'hFFFF_FFFF - $urandom_range(200);
        step = 16;
      end
    endcase
    for (int i = 0; i < count && edges_sent < EDGE_TARGET; i++) begin
      sum = {1'b0, wt} + {1'b0, $urandom_range(step)};
      wt  = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
      if ($urandom_range(99) < 10) begin
        // Noise: any vertices, any weight, order ignored.
        raw = {$urandom(), $urandom()};
        w   = raw[$bits(kmst_in_t)-1:0];
        w.new_graph = (i == 0);
        send_edge(w);
      end else begin
        send_fields(i == 0 || $urandom_range(99) == 0, wt,
                    base + $urandom_range(span - 1), base + $urandom_range(span - 1));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    calm           = 1'b0;
    edges_sent     = 0;
    graphs_started = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed edges: the widest vertex pair, zero and all-ones weights,
    // an edge inside one component, self loops, a weight that goes down,
    // and a chain long enough that the root walk has to compress a path.
    send_fields(1'b1, 32'd0,          0,    NODES - 1);
    send_fields(1'b0, 32'd1,          NODES - 1, 0);
    send_fields(1'b0, 32'd2,          5,    5);
    send_fields(1'b0, 32'd3,          1,    2);
    send_fields(1'b0, 32'hFFFF_FFFF,  2,    3);
    send_fields(1'b0, 32'hFFFF_FFFF,  0,    3);
    send_fields(1'b0, 32'd7,          4,    6);
    send_fields(1'b0, 32'd8,          10,   11);
    send_fields(1'b0, 32'd9,          9,    10);
    send_fields(1'b0, 32'd10,         8,    9);
    send_fields(1'b0, 32'd11,         7,    8);
    send_fields(1'b0, 32'd12,         11,   12);
    send_fields(1'b0, 32'd13,         12,   7);
    send_fields(1'b0, 32'hFFFF_FFFF,  NODES - 1, 512);
    send_fields(1'b0, 32'hAAAA_AAAA,  341,  682);
    send_fields(1'b1, 32'hFFFF_FFFF,  NODES - 1, NODES - 1);
    send_fields(1'b0, 32'hFFFF_FFFF,  NODES - 2, NODES - 1);
    send_fields(1'b0, 32'h5555_5555,  682,  341);
    send_fields(1'b1, 32'd0,          0,    0);
    send_fields(1'b0, 32'hFFFF_FFFF,  0,    1);

    while (edges_sent < EDGE_TARGET) send_graph();
    in_valid <= 1'b0;

    // Drain every expected word, then watch a while for anything extra.
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d edge words across %0d graphs; %0d result words checked, %0d joins.",
             edges_sent, graphs_started, sb.checked, sb.joins);
    $display("Mismatches: %0d, words still awaited: %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("kruskal_union_find_mst verification clean");
    end else begin
      $display("kruskal_union_find_mst verification failed");
    end
    $finish;
  end

endmodule
